// ----- design/cct_pkg.sv -----
package cct_pkg;

    localparam int MAX_YEARS       = 16;
    localparam int DAYS_PER_YEAR   = 366;
    localparam int MONTHS_PER_YEAR = 12;

    localparam int PW   = (MAX_YEARS > 1) ? $clog2(MAX_YEARS) : 1;
    localparam int CW   = $clog2(MAX_YEARS + 1);
    localparam int MA_W = $clog2(MAX_YEARS * MONTHS_PER_YEAR);
    localparam int DA_W = $clog2(MAX_YEARS * DAYS_PER_YEAR);
    localparam int DW   = $clog2(DAYS_PER_YEAR);

    localparam logic REQ_ACCUM = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef enum logic [2:0] {
        ST_UPDATED   = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_FULL      = 3'd2,
        ST_BAD_DATE  = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_CLEAR,
        S_READ,
        S_MODIFY,
        S_EMIT
    } t_state;

endpackage

// ----- design/cct_if.sv -----
interface cct_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [15:0]        year;
    logic [3:0]         month;
    logic [8:0]         day_of_year;
    logic signed [63:0] add_value;

    modport source(output valid, req_type, year, month, day_of_year, add_value, input ready);
    modport sink(input valid, req_type, year, month, day_of_year, add_value, output ready);
endinterface

interface cct_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [3:0]         slot;
    logic signed [63:0] day_total;
    logic signed [63:0] month_total;
    logic signed [63:0] year_total;

    modport source(output valid, status, slot, day_total, month_total, year_total, input ready);
    modport sink(input valid, status, slot, day_total, month_total, year_total, output ready);
endinterface

// ----- design/cct_ram.sv -----
module cct_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- design/calendar_counter_table.sv -----
// Path: a request is taken in S_IDLE and checked in S_SEARCH; a bad date goes
//   to S_EMIT, a refused item (table full or year not found) goes via S_DECIDE
//   to S_EMIT, a hit via S_DECIDE, S_READ and S_MODIFY, an insert adds S_CLEAR.
// Concurrency: one transaction at a time; an insert is bound by the
//   clear of the new record's day totals through one RAM write port.
// Reset (synchronous, active low) empties the table; the RAMs are not cleared,
//   each record is cleared when it is inserted.
module calendar_counter_table
    import cct_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    cct_req_if.sink     i_req,
    cct_rsp_if.source   o_rsp
);
    localparam int YA_W = PW;

    t_state             r_state, n_state;
    logic               r_type;
    logic [15:0]        r_year;
    logic [3:0]         r_month;
    logic [8:0]         r_day;
    logic [63:0]        r_val;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [15:0]        r_keys [MAX_YEARS];
    logic [15:0]        n_keys [MAX_YEARS];
    logic [PW-1:0]      r_map  [MAX_YEARS];
    logic [PW-1:0]      n_map  [MAX_YEARS];
    logic [CW-1:0]      r_pos, n_pos;
    logic               r_hit, n_hit;
    logic [PW-1:0]      r_phys, n_phys;
    logic [DW-1:0]      r_clr, n_clr;
    t_status            r_st, n_st;
    logic [63:0]        r_dsum, n_dsum, r_msum, n_msum, r_ysum, n_ysum;
    logic               r_ovalid;
    t_status            r_ost;
    logic [3:0]         r_oslot;
    logic [63:0]        r_od, r_om, r_oy;

    logic [CW-1:0]      c_pos;
    logic               c_hit, c_bad, c_emit;
    logic [DW-1:0]      c_d;
    logic [3:0]         c_m;
    logic [DA_W-1:0]    c_dbase;
    logic [MA_W-1:0]    c_mbase;
    logic               d_we, m_we, y_we;
    logic [DA_W-1:0]    d_addr;
    logic [MA_W-1:0]    m_addr;
    logic [YA_W-1:0]    y_addr;
    logic [63:0]        d_wdata, m_wdata, y_wdata, d_rdata, m_rdata, y_rdata, c_add;

    assign c_bad = (r_month < 4'd1) || (r_month > 4'(MONTHS_PER_YEAR)) ||
                   (r_day < 9'd1) || (r_day > 9'(DAYS_PER_YEAR));
    assign c_d   = DW'(r_day - 9'd1);
    assign c_m   = r_month - 4'd1;

    always_comb begin
        c_pos = '0;
        for (int i = 0; i < MAX_YEARS; i++) begin
            if ((CW'(i) < r_cnt) && (r_keys[i] < r_year)) begin
                c_pos = c_pos + CW'(1);
            end
        end
        c_hit = (c_pos < r_cnt) && (r_keys[c_pos[PW-1:0]] == r_year);
    end

    assign c_dbase = DA_W'(r_phys) * DA_W'(DAYS_PER_YEAR);
    assign c_mbase = MA_W'(r_phys) * MA_W'(MONTHS_PER_YEAR);
    assign c_emit  = !r_ovalid || o_rsp.ready;
    assign c_add   = (r_type == REQ_ACCUM) ? r_val : 64'd0;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_req.valid) n_state = S_SEARCH;
            S_SEARCH: n_state = c_bad ? S_EMIT : S_DECIDE;
            S_DECIDE: begin
                if (r_hit) begin
                    n_state = S_READ;
                end else if (r_type == REQ_READ || r_cnt >= CW'(MAX_YEARS)) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR:  if (r_clr == DW'(DAYS_PER_YEAR - 1)) n_state = S_READ;
            S_READ:   n_state = S_MODIFY;
            S_MODIFY: n_state = S_EMIT;
            S_EMIT:   if (c_emit) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cnt  = r_cnt;
        n_keys = r_keys;
        n_map  = r_map;
        n_pos  = r_pos;
        n_hit  = r_hit;
        n_phys = r_phys;
        n_clr  = r_clr;
        n_st   = r_st;
        n_dsum = r_dsum;
        n_msum = r_msum;
        n_ysum = r_ysum;
        d_we   = 1'b0;
        m_we   = 1'b0;
        y_we   = 1'b0;
        d_addr = c_dbase + DA_W'(c_d);
        m_addr = c_mbase + MA_W'(c_m);
        y_addr = YA_W'(r_phys);
        d_wdata = d_rdata + c_add;
        m_wdata = m_rdata + c_add;
        y_wdata = y_rdata + c_add;
        unique case (r_state)
            S_SEARCH: begin
                n_pos = c_pos;
                n_hit = c_hit;
                n_st  = ST_BAD_DATE;
            end
            S_DECIDE: begin
                n_st = (r_type == REQ_READ) ? ST_NOT_FOUND : ST_FULL;
                if (r_hit) begin
                    n_phys = r_map[r_pos[PW-1:0]];
                    n_st   = ST_UPDATED;
                end else if (r_type == REQ_ACCUM && r_cnt < CW'(MAX_YEARS)) begin
                    for (int i = 1; i < MAX_YEARS; i++) begin
                        if (CW'(i) > r_pos) begin
                            n_keys[i] = r_keys[i-1];
                            n_map[i]  = r_map[i-1];
                        end
                    end
                    n_keys[r_pos[PW-1:0]] = r_year;
                    n_map[r_pos[PW-1:0]]  = r_cnt[PW-1:0];
                    n_phys = r_cnt[PW-1:0];
                    n_cnt  = r_cnt + CW'(1);
                    n_clr  = '0;
                    n_st   = ST_INSERTED;
                end
            end
            S_CLEAR: begin
                d_we    = 1'b1;
                m_we    = (r_clr < DW'(MONTHS_PER_YEAR));
                y_we    = (r_clr == '0);
                d_addr  = c_dbase + DA_W'(r_clr);
                m_addr  = c_mbase + MA_W'(r_clr);
                d_wdata = '0;
                m_wdata = '0;
                y_wdata = '0;
                n_clr   = r_clr + DW'(1);
            end
            S_MODIFY: begin
                d_we   = (r_type == REQ_ACCUM);
                m_we   = (r_type == REQ_ACCUM);
                y_we   = (r_type == REQ_ACCUM);
                n_dsum = d_wdata;
                n_msum = m_wdata;
                n_ysum = y_wdata;
            end
            default: ;
        endcase
    end

    cct_ram #(.WIDTH(64), .DEPTH(MAX_YEARS * DAYS_PER_YEAR)) u_day_ram (
        .i_clk, .i_we(d_we), .i_waddr(d_addr), .i_wdata(d_wdata),
        .i_raddr(d_addr), .o_rdata(d_rdata)
    );
    cct_ram #(.WIDTH(64), .DEPTH(MAX_YEARS * MONTHS_PER_YEAR)) u_month_ram (
        .i_clk, .i_we(m_we), .i_waddr(m_addr), .i_wdata(m_wdata),
        .i_raddr(m_addr), .o_rdata(m_rdata)
    );
    cct_ram #(.WIDTH(64), .DEPTH(MAX_YEARS)) u_year_ram (
        .i_clk, .i_we(y_we), .i_waddr(y_addr), .i_wdata(y_wdata),
        .i_raddr(y_addr), .o_rdata(y_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (r_state == S_EMIT && c_emit) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && r_state == S_IDLE) begin
            r_type  <= i_req.req_type;
            r_year  <= i_req.year;
            r_month <= i_req.month;
            r_day   <= i_req.day_of_year;
            r_val   <= i_req.add_value;
        end
        r_keys <= n_keys;
        r_map  <= n_map;
        r_pos  <= n_pos;
        r_hit  <= n_hit;
        r_phys <= n_phys;
        r_clr  <= n_clr;
        r_st   <= n_st;
        r_dsum <= n_dsum;
        r_msum <= n_msum;
        r_ysum <= n_ysum;
        if (r_state == S_EMIT && c_emit) begin
            r_ost <= r_st;
            if (r_st == ST_UPDATED || r_st == ST_INSERTED) begin
                r_oslot <= 4'(r_pos);
                r_od    <= r_dsum;
                r_om    <= r_msum;
                r_oy    <= r_ysum;
            end else begin
                r_oslot <= '0;
                r_od    <= '0;
                r_om    <= '0;
                r_oy    <= '0;
            end
        end
    end

    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.status      = r_ost;
    assign o_rsp.slot        = r_oslot;
    assign o_rsp.day_total   = r_od;
    assign o_rsp.month_total = r_om;
    assign o_rsp.year_total  = r_oy;
endmodule

// ----- design/cct_checker.sv -----
module cct_sva
    import cct_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_status,
    input logic [3:0]  i_slot,
    input logic [63:0] i_day,
    input logic [63:0] i_month,
    input logic [63:0] i_year
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("response dropped while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("response valid after reset");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status <= 3'(ST_NOT_FOUND)))
        else $error("status code out of range");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == 3'(ST_FULL) || i_status == 3'(ST_BAD_DATE) ||
        i_status == 3'(ST_NOT_FOUND)) |->
        (i_slot == '0 && i_day == '0 && i_month == '0 && i_year == '0))
        else $error("failed transaction carries data");
endmodule

bind calendar_counter_table cct_sva u_cct_sva (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_out_valid(o_rsp.valid),
    .i_out_ready(o_rsp.ready),
    .i_status(o_rsp.status),
    .i_slot(o_rsp.slot),
    .i_day(o_rsp.day_total),
    .i_month(o_rsp.month_total),
    .i_year(o_rsp.year_total)
);
